// File: rtl/ott_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ott_pkg
// Types and codes shared by the operation tracking table.
// ---------------------------------------------------------------------------
package ott_pkg;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_CANCEL = 3'd4;
	localparam logic [2:0] OP_FIND   = 3'd5;
	localparam logic [2:0] OP_SWEEP  = 3'd6;

	localparam logic [2:0] PH_PENDING   = 3'd0;
	localparam logic [2:0] PH_RUNNING   = 3'd1;
	localparam logic [2:0] PH_SUCCEEDED = 3'd2;
	localparam logic [2:0] PH_FAILED    = 3'd3;
	localparam logic [2:0] PH_CANCELED  = 3'd4;

	localparam logic [2:0] C_OK       = 3'd0;
	localparam logic [2:0] C_ARG      = 3'd1;
	localparam logic [2:0] C_NOTFOUND = 3'd2;
	localparam logic [2:0] C_NOROOM   = 3'd3;
	localparam logic [2:0] C_STATE    = 3'd4;
	localparam logic [2:0] C_NOTSUP   = 3'd5;
	localparam logic [2:0] C_REFUSED  = 3'd6;

	localparam logic [1:0] REG_BOOT  = 2'd0;
	localparam logic [1:0] REG_RET   = 2'd1;
	localparam logic [1:0] REG_UNAV  = 2'd2;
	localparam logic [1:0] REG_HIGH  = 2'd3;

	// One table entry; id zero means the slot is free.
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] owner;
		logic [7:0]  domain;
		logic [7:0]  method;
		logic [2:0]  phase;
		logic [3:0]  status;
		logic [7:0]  len;
		logic        creq;
		logic        canc;
		logic        decl;
		logic [47:0] done_time;
	} slot_t;

	function automatic logic is_term(input logic [2:0] ph);
		return (ph == PH_SUCCEEDED) || (ph == PH_FAILED) || (ph == PH_CANCELED);
	endfunction

endpackage
`default_nettype wire

// File: rtl/operation_tracking_table_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// operation_tracking_table_top
// Table of tracked operations held in one slot memory, one request at a time.
// ---------------------------------------------------------------------------
//  channel  direction  contents
//  s_axis   in         request item (op, time, ids, update fields, flags)
//  m_axis   out        answer item (code and reported slot)
//  cfg      in         register writes (index, data)
//
// An answer follows its request through the states ST_FIX (argument checks),
// ST_SCAN (one memory read per slot), ST_WRITE (write-back) and ST_OUT, which
// raises the output. Clear and sweep skip the write-back; an argument error
// skips the scan. After reset a clearing pass writes every slot before the
// first item is taken. A finished answer waits in the output register; the
// next item can be taken in the cycle after the answer has left.
module operation_tracking_table_top #(
	parameter int NUM_SLOTS  = 8,
	parameter int RESULT_MAX = 255
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [2:0] op, [50:3] now_ms, [82:51] target id, [114:83] owner,
	// [122:115] domain, [130:123] method, [133:131] new_state,
	// [137:134] new_status, [145:138] length, [146] cancellable,
	// [147] result_declared, [148] lower_ok, rest zero
	input  wire logic [151:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [2:0] code, [34:3] found_id, [66:35] found_owner, [74:67] found_domain,
	// [82:75] found_method, [85:83] found_state, [89:86] found_status,
	// [97:90] found_len, [98] found_cancel_req, rest zero
	output logic [103:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import ott_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_SCAN, ST_WRITE, ST_FIX, ST_OUT
	} state_t;

	state_t      state_q;
	slot_t       mem [NUM_SLOTS];
	slot_t       rd_q;
	logic [IW-1:0] raddr_q;
	logic [CW-1:0] cnt_q;      // slots issued
	logic        rvalid_q;
	logic [IW-1:0] rslot_q;
	logic        hit_q;
	logic [IW-1:0] hit_idx_q;
	slot_t       hit_slot_q;
	logic        free_q;
	logic [IW-1:0] free_idx_q;

	logic [2:0]  op_q;
	logic [47:0] now_q;
	logic [31:0] opid_q, owner_q;
	logic [7:0]  dom_q, meth_q, rlen_q;
	logic [2:0]  nst_q;
	logic [3:0]  nsts_q;
	logic        canc_q, decl_q, ok_q;

	logic [31:0] boot_q, ret_q, next_id_q;
	logic [3:0]  unav_q, high_q;

	logic [2:0]  code_q;
	slot_t       rep_q;

	logic        we;
	logic [IW-1:0] waddr;
	slot_t       wdata;

	// Per-slot scan logic on the read data.
	slot_t       cur;
	logic        expire, sweeps, match;
	logic [48:0] diff;

	assign cfg_ready = (state_q == ST_IDLE) && !s_axis_tvalid;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		sweeps = (op_q == OP_START) || (op_q == OP_GET) || (op_q == OP_CANCEL)
			|| (op_q == OP_SWEEP);
		diff = {1'b0, now_q} - {1'b0, rd_q.done_time};
		expire = sweeps && (rd_q.id != 32'd0) && is_term(rd_q.phase) && !diff[48]
			&& (diff[47:0] >= {16'd0, ret_q});
		cur = expire ? '0 : rd_q;
		case (op_q)
			OP_START: match = 1'b0;
			OP_FIND:  match = (cur.id != 32'd0) && (cur.owner == owner_q)
				&& !is_term(cur.phase);
			default:  match = (cur.id == opid_q) && (opid_q != 32'd0);
		endcase
	end

	// Update argument checks that need no slot.
	logic upd_arg;
	always_comb begin
		logic infl, nons;
		infl = (nst_q == PH_PENDING) || (nst_q == PH_RUNNING);
		nons = (nst_q == PH_FAILED) || (nst_q == PH_CANCELED);
		upd_arg = (opid_q == 32'd0) || (nst_q > PH_CANCELED) || (nsts_q > high_q)
			|| ({24'd0, rlen_q} > RESULT_MAX) || (infl && nsts_q != 4'd0)
			|| (nst_q == PH_SUCCEEDED && nsts_q != 4'd0) || (infl && rlen_q != 8'd0)
			|| (nst_q == PH_FAILED && nsts_q == 4'd0)
			|| (nst_q == PH_CANCELED && nsts_q != 4'd0) || (nons && rlen_q != 8'd0);
	end

	// Final decision once the scan is over.
	logic [2:0] fin_code;
	logic       fin_we, fin_rep;
	slot_t      fin_w;
	logic [IW-1:0] fin_a;
	always_comb begin
		logic [2:0] st;
		logic [3:0] sts;
		logic [7:0] ln;
		fin_code = C_OK;
		fin_we = 1'b0;
		fin_rep = 1'b0;
		fin_w = hit_slot_q;
		fin_a = hit_idx_q;
		st = nst_q;
		sts = nsts_q;
		ln = rlen_q;
		case (op_q)
			OP_START: begin
				if (!free_q || next_id_q == 32'd0) begin
					fin_code = C_NOROOM;
				end else begin
					fin_we = 1'b1;
					fin_rep = 1'b1;
					fin_a = free_idx_q;
					fin_w = '0;
					fin_w.id = next_id_q;
					fin_w.owner = owner_q;
					fin_w.domain = dom_q;
					fin_w.method = meth_q;
					fin_w.canc = canc_q;
					fin_w.decl = decl_q;
				end
			end
			OP_GET, OP_FIND: begin
				if (!hit_q) fin_code = C_NOTFOUND;
				else fin_rep = 1'b1;
			end
			OP_CANCEL: begin
				if (!hit_q) fin_code = C_NOTFOUND;
				else if (is_term(hit_slot_q.phase)) fin_code = C_STATE;
				else if (hit_slot_q.creq) fin_code = C_OK;
				else if (!hit_slot_q.canc) fin_code = C_NOTSUP;
				else if (!ok_q) fin_code = C_REFUSED;
				else begin
					fin_we = 1'b1;
					fin_w.creq = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (!hit_q) fin_code = C_NOTFOUND;
				else if (is_term(hit_slot_q.phase)
					|| (hit_slot_q.phase == PH_RUNNING && nst_q == PH_PENDING))
					fin_code = C_STATE;
				else begin
					if (hit_slot_q.creq && is_term(nst_q)
						&& !(nst_q == PH_FAILED && nsts_q == unav_q)) begin
						st = PH_CANCELED;
						sts = 4'd0;
						ln = 8'd0;
					end
					if (st == PH_SUCCEEDED && ((!hit_slot_q.decl && ln != 8'd0)
						|| (hit_slot_q.decl && (ln == 8'd0 || !ok_q)))) begin
						fin_code = C_ARG;
					end else begin
						fin_we = 1'b1;
						fin_w.phase = st;
						fin_w.status = sts;
						fin_w.len = ln;
						if (is_term(st)) fin_w.done_time = now_q;
					end
				end
			end
			default: fin_code = C_OK;
		endcase
	end

	// Memory write port: sweep write-back, clear pass or final update.
	always_comb begin
		we = 1'b0;
		waddr = rslot_q;
		wdata = cur;
		if (state_q == ST_INIT || (state_q == ST_SCAN && op_q == OP_CLEAR)) begin
			we = (state_q == ST_INIT) || rvalid_q;
			waddr = (state_q == ST_INIT) ? raddr_q : rslot_q;
			wdata = '0;
		end else if (state_q == ST_SCAN) begin
			we = rvalid_q && expire;
		end else if (state_q == ST_WRITE) begin
			we = fin_we;
			waddr = fin_a;
			wdata = fin_w;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			raddr_q <= '0;
			cnt_q <= '0;
			rvalid_q <= 1'b0;
			rslot_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			boot_q <= 32'd0;
			ret_q <= 32'd5000;
			unav_q <= 4'd1;
			high_q <= 4'd15;
			next_id_q <= 32'd1;
			m_axis_tvalid <= 1'b0;
			code_q <= C_OK;
			op_q <= OP_CLEAR;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_BOOT: boot_q <= cfg_data;
					REG_RET:  ret_q <= cfg_data;
					REG_UNAV: unav_q <= cfg_data[3:0];
					REG_HIGH: high_q <= cfg_data[3:0];
					default:  boot_q <= boot_q;
				endcase
			end
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == CW'(NUM_SLOTS - 1)) begin
						state_q <= ST_IDLE;
						raddr_q <= '0;
						cnt_q <= '0;
					end else begin
						raddr_q <= raddr_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= s_axis_tdata[2:0];
						now_q <= s_axis_tdata[50:3];
						opid_q <= s_axis_tdata[82:51];
						owner_q <= s_axis_tdata[114:83];
						dom_q <= s_axis_tdata[122:115];
						meth_q <= s_axis_tdata[130:123];
						nst_q <= s_axis_tdata[133:131];
						nsts_q <= s_axis_tdata[137:134];
						rlen_q <= s_axis_tdata[145:138];
						canc_q <= s_axis_tdata[146];
						decl_q <= s_axis_tdata[147];
						ok_q <= s_axis_tdata[148];
						state_q <= ST_FIX;
						rep_q <= '0;
					end
				end
				ST_FIX: begin
					// Argument checks; a failed check ends the item without a scan.
					hit_q <= 1'b0;
					free_q <= 1'b0;
					raddr_q <= '0;
					cnt_q <= '0;
					rvalid_q <= 1'b0;
					case (op_q)
						OP_CLEAR: begin
							if (boot_q == 32'd0) begin
								code_q <= C_ARG;
								state_q <= ST_OUT;
							end else begin
								next_id_q <= 32'd1;
								code_q <= C_OK;
								state_q <= ST_SCAN;
							end
						end
						OP_START: begin
							if (boot_q == 32'd0 || dom_q == 8'd0 || meth_q == 8'd0
								|| owner_q == 32'd0) begin
								code_q <= C_ARG;
								state_q <= ST_OUT;
							end else state_q <= ST_SCAN;
						end
						OP_UPDATE: begin
							if (upd_arg) begin
								code_q <= C_ARG;
								state_q <= ST_OUT;
							end else state_q <= ST_SCAN;
						end
						OP_GET, OP_CANCEL: begin
							if (opid_q == 32'd0) begin
								code_q <= C_ARG;
								state_q <= ST_OUT;
							end else state_q <= ST_SCAN;
						end
						OP_FIND, OP_SWEEP: state_q <= ST_SCAN;
						default: begin
							code_q <= C_ARG;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_SCAN: begin
					// Reads go out one per cycle; data returns in the cycle after.
					if (cnt_q != CW'(NUM_SLOTS)) begin
						raddr_q <= raddr_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
					rvalid_q <= (cnt_q != CW'(NUM_SLOTS));
					rslot_q <= raddr_q;
					if (rvalid_q) begin
						if (match && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= rslot_q;
							hit_slot_q <= cur;
						end
						if (cur.id == 32'd0 && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= rslot_q;
						end
					end
					if (rvalid_q && cnt_q == CW'(NUM_SLOTS)) begin
						state_q <= (op_q == OP_CLEAR || op_q == OP_SWEEP) ? ST_OUT : ST_WRITE;
						if (op_q == OP_CLEAR || op_q == OP_SWEEP) code_q <= C_OK;
					end
				end
				ST_WRITE: begin
					code_q <= fin_code;
					if (fin_rep) rep_q <= (op_q == OP_START) ? fin_w : hit_slot_q;
					if (op_q == OP_START && fin_we) next_id_q <= next_id_q + 32'd1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_axis_tvalid) m_axis_tvalid <= 1'b1;
					else if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {5'd0, rep_q.creq, rep_q.len, rep_q.status, rep_q.phase,
		rep_q.method, rep_q.domain, rep_q.owner, rep_q.id, code_q};

	// The input side is closed while an answer waits.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input open with answer pending");
	// An answer holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("answer changed while stalled");
	// A reported error carries no slot.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2:0] != C_OK) |-> (m_axis_tdata[34:3] == 32'd0))
		else $error("error answer carries an id");
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the operation tracking table against a predictor of its own. Each
// accepted request item updates a copy of the slot table and queues the
// expected answer; a monitor compares each answer item field by field.
// ---------------------------------------------------------------------------
module tb;
	import ott_pkg::*;

	localparam int NSLOT = 8;
	localparam int LEN_MAX = 255;

	// Fields from the highest bit down, so code lands in the lowest bits.
	typedef struct packed {
		logic        creq;
		logic [7:0]  len;
		logic [3:0]  status;
		logic [2:0]  phase;
		logic [7:0]  method;
		logic [7:0]  domain;
		logic [31:0] owner;
		logic [31:0] id;
		logic [2:0]  code;
	} answer_t;

	typedef struct packed {
		logic        ok;
		logic        decl;
		logic        canc;
		logic [7:0]  len;
		logic [3:0]  status;
		logic [2:0]  phase;
		logic [7:0]  method;
		logic [7:0]  domain;
		logic [31:0] owner;
		logic [31:0] opid;
		logic [47:0] now;
		logic [2:0]  op;
	} request_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [151:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [103:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	operation_tracking_table_top dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb: FAIL");
		$finish;
	end

	// Predictor state
	slot_t       table_q [NSLOT];
	logic [31:0] next_id;
	logic [31:0] r_boot, r_ret;
	logic [3:0]  r_unav, r_high;

	answer_t answers_due[$];
	int errors = 0;
	int hold_off = 0;
	logic [47:0] clock_ms = 0;

	function automatic logic terminal(input logic [2:0] ph);
		return ph == PH_SUCCEEDED || ph == PH_FAILED || ph == PH_CANCELED;
	endfunction

	function automatic void expire_slots(input logic [47:0] now);
		for (int i = 0; i < NSLOT; i++)
			if (table_q[i].id != 0 && terminal(table_q[i].phase) &&
					now >= table_q[i].done_time &&
					now - table_q[i].done_time >= {16'd0, r_ret})
				table_q[i] = '0;
	endfunction

	function automatic int slot_of(input logic [31:0] id);
		for (int i = 0; i < NSLOT; i++)
			if (table_q[i].id == id) return i;
		return -1;
	endfunction

	function automatic answer_t report_slot(input int i);
		answer_t a;
		a = '0;
		a.id = table_q[i].id;
		a.owner = table_q[i].owner;
		a.domain = table_q[i].domain;
		a.method = table_q[i].method;
		a.phase = table_q[i].phase;
		a.status = table_q[i].status;
		a.len = table_q[i].len;
		a.creq = table_q[i].creq;
		return a;
	endfunction

	function automatic logic [2:0] apply_update(input request_t r);
		logic [2:0] st;
		logic [3:0] sts;
		logic [7:0] len;
		logic inflight, nonsucc;
		int i;
		st = r.phase;
		sts = r.status;
		len = r.len;
		if (r.opid == 0 || st > PH_CANCELED || sts > r_high || len > LEN_MAX) return C_ARG;
		inflight = st == PH_PENDING || st == PH_RUNNING;
		nonsucc = st == PH_FAILED || st == PH_CANCELED;
		if ((inflight && sts != 0) || (st == PH_SUCCEEDED && sts != 0) ||
				(inflight && len != 0) || (st == PH_FAILED && sts == 0) ||
				(st == PH_CANCELED && sts != 0) || (nonsucc && len != 0))
			return C_ARG;
		i = slot_of(r.opid);
		if (i < 0) return C_NOTFOUND;
		if (terminal(table_q[i].phase) ||
				(table_q[i].phase == PH_RUNNING && st == PH_PENDING))
			return C_STATE;
		// A pending cancel wins unless the failure is the unavailable one.
		if (table_q[i].creq && terminal(st) && !(st == PH_FAILED && sts == r_unav)) begin
			st = PH_CANCELED;
			sts = 0;
			len = 0;
		end
		if (st == PH_SUCCEEDED) begin
			if ((!table_q[i].decl && len != 0) ||
					(table_q[i].decl && (len == 0 || !r.ok)))
				return C_ARG;
		end
		table_q[i].phase = st;
		table_q[i].status = sts;
		table_q[i].len = len;
		if (terminal(st)) table_q[i].done_time = r.now;
		return C_OK;
	endfunction

	function automatic answer_t predict_answer(input request_t r);
		answer_t a;
		int i;
		a = '0;
		case (r.op)
			OP_CLEAR: begin
				if (r_boot == 0) a.code = C_ARG;
				else begin
					foreach (table_q[k]) table_q[k] = '0;
					next_id = 1;
				end
			end
			OP_START: begin
				if (r_boot == 0 || r.domain == 0 || r.method == 0 || r.owner == 0)
					a.code = C_ARG;
				else begin
					expire_slots(r.now);
					i = slot_of(0);
					if (i < 0 || next_id == 0) a.code = C_NOROOM;
					else begin
						table_q[i] = '0;
						table_q[i].id = next_id;
						next_id = next_id + 1;
						table_q[i].owner = r.owner;
						table_q[i].domain = r.domain;
						table_q[i].method = r.method;
						table_q[i].canc = r.canc;
						table_q[i].decl = r.decl;
						a = report_slot(i);
					end
				end
			end
			OP_UPDATE: a.code = apply_update(r);
			OP_GET: begin
				if (r.opid == 0) a.code = C_ARG;
				else begin
					expire_slots(r.now);
					i = slot_of(r.opid);
					if (i < 0) a.code = C_NOTFOUND;
					else a = report_slot(i);
				end
			end
			OP_CANCEL: begin
				if (r.opid == 0) a.code = C_ARG;
				else begin
					expire_slots(r.now);
					i = slot_of(r.opid);
					if (i < 0) a.code = C_NOTFOUND;
					else if (terminal(table_q[i].phase)) a.code = C_STATE;
					else if (table_q[i].creq) a.code = C_OK;
					else if (!table_q[i].canc) a.code = C_NOTSUP;
					else if (!r.ok) a.code = C_REFUSED;
					else table_q[i].creq = 1;
				end
			end
			OP_FIND: begin
				a.code = C_NOTFOUND;
				for (int k = 0; k < NSLOT; k++)
					if (table_q[k].id != 0 && table_q[k].owner == r.owner &&
							!terminal(table_q[k].phase)) begin
						a = report_slot(k);
						break;
					end
			end
			OP_SWEEP: expire_slots(r.now);
			default: a.code = C_ARG;
		endcase
		return a;
	endfunction

	// Valid stays up after an accept until the next gap, a register write or a
	// drain drops it; the block is busy after every accept.
	task automatic send_request(input request_t r);
		int gap;
		gap = $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {3'b000, r};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		answers_due.push_back(predict_answer(r));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		s_axis_tvalid <= 0;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_BOOT: r_boot = val;
			REG_RET:  r_ret = val;
			REG_UNAV: r_unav = val[3:0];
			default:  r_high = val[3:0];
		endcase
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (2 * NSLOT + 8) @(posedge clk);
	endtask

	// Answer monitor and receiver stalls
	initial begin
		answer_t got, want;
		int wait_n;
		wait_n = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[98:0];
				if (answers_due.size() == 0) begin
					$error("unexpected answer %h", got);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (got.code != want.code) begin
						$error("code exp %0d got %0d", want.code, got.code); errors++; end
					if (got.id != want.id) begin
						$error("found_id exp %0d got %0d", want.id, got.id); errors++; end
					if (got.owner != want.owner) begin
						$error("found_owner exp %0d got %0d", want.owner, got.owner); errors++; end
					if (got.domain != want.domain) begin
						$error("found_domain exp %0d got %0d", want.domain, got.domain); errors++; end
					if (got.method != want.method) begin
						$error("found_method exp %0d got %0d", want.method, got.method); errors++; end
					if (got.phase != want.phase) begin
						$error("found_state exp %0d got %0d", want.phase, got.phase); errors++; end
					if (got.status != want.status) begin
						$error("found_status exp %0d got %0d", want.status, got.status); errors++; end
					if (got.len != want.len) begin
						$error("found_len exp %0d got %0d", want.len, got.len); errors++; end
					if (got.creq != want.creq) begin
						$error("found_cancel_req exp %0d got %0d", want.creq, got.creq); errors++; end
				end
				wait_n = $urandom_range(0, 12);
				if ($urandom_range(0, 3) == 0) wait_n = 0;
			end
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 0;
			end else if (wait_n > 0) begin
				wait_n--;
				m_axis_tready <= 0;
			end else
				m_axis_tready <= 1;
		end
	end

	function automatic request_t noise_request();
		request_t r;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[148:0];
		r.now = clock_ms;
		return r;
	endfunction

	// Mostly well-formed traffic on live ids with random content.
	function automatic request_t life_request();
		request_t r;
		int pick;
		r = '0;
		clock_ms = clock_ms + $urandom_range(0, 3000);
		r.now = clock_ms;
		r.opid = ($urandom_range(0, 9) == 0) ? $urandom : next_id - $urandom_range(1, 10);
		r.owner = $urandom_range(1, 4);
		r.domain = $urandom_range(0, 20) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
		r.method = $urandom_range(0, 20) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
		r.canc = 1'($urandom);
		r.decl = 1'($urandom);
		r.ok = $urandom_range(0, 4) != 0;
		pick = $urandom_range(0, 99);
		if (pick < 25) r.op = OP_START;
		else if (pick < 60) r.op = OP_UPDATE;
		else if (pick < 70) r.op = OP_GET;
		else if (pick < 82) r.op = OP_CANCEL;
		else if (pick < 90) r.op = OP_FIND;
		else if (pick < 96) r.op = OP_SWEEP;
		else if (pick < 98) r.op = OP_CLEAR;
		else r.op = 3'd7;
		r.phase = 3'($urandom_range(0, 4));
		if ($urandom_range(0, 30) == 0) r.phase = 3'($urandom_range(5, 7));
		case (r.phase)
			PH_FAILED: r.status = 4'($urandom_range(1, 15));
			PH_SUCCEEDED: r.len = r.decl ? 8'($urandom_range(1, 255)) : 8'd0;
			default: ;
		endcase
		if ($urandom_range(0, 10) == 0) r.status = 4'($urandom);
		if ($urandom_range(0, 10) == 0) r.len = 8'($urandom);
		return r;
	endfunction

	function automatic request_t make_req(input logic [2:0] op, input logic [31:0] opid,
			input logic [2:0] ph, input logic [3:0] sts, input logic [7:0] len,
			input logic ok);
		request_t r;
		r = '0;
		r.op = op;
		r.now = clock_ms;
		r.opid = opid;
		r.owner = 32'hFFFF_FFFF;
		r.domain = 8'hFF;
		r.method = 8'h01;
		r.phase = ph;
		r.status = sts;
		r.len = len;
		r.canc = 1;
		r.decl = 1;
		r.ok = ok;
		return r;
	endfunction

	task automatic test_directed;
		send_request(make_req(OP_START, 0, 0, 0, 0, 1));     // boot id zero
		send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 1));
		send_request(make_req(3'd7, 0, 0, 0, 0, 1));
		drain();
		write_reg(REG_BOOT, 32'hFFFF_FFFF);
		write_reg(REG_RET, 0);
		write_reg(REG_UNAV, 15);
		write_reg(REG_HIGH, 15);
		for (int i = 0; i < NSLOT + 1; i++)                  // fill and overflow
			send_request(make_req(OP_START, 0, 0, 0, 0, 1));
		send_request(make_req(OP_UPDATE, 1, PH_RUNNING, 0, 0, 1));
		send_request(make_req(OP_UPDATE, 1, PH_PENDING, 0, 0, 1));
		send_request(make_req(OP_UPDATE, 2, PH_SUCCEEDED, 0, 255, 1));
		send_request(make_req(OP_UPDATE, 3, PH_SUCCEEDED, 0, 0, 1));
		send_request(make_req(OP_CANCEL, 4, 0, 0, 0, 0));
		send_request(make_req(OP_CANCEL, 4, 0, 0, 0, 1));
		send_request(make_req(OP_CANCEL, 4, 0, 0, 0, 1));
		send_request(make_req(OP_UPDATE, 4, PH_FAILED, 15, 0, 1));
		send_request(make_req(OP_GET, 4, 0, 0, 0, 1));
		send_request(make_req(OP_GET, 0, 0, 0, 0, 1));
		send_request(make_req(OP_FIND, 0, 0, 0, 0, 1));
		clock_ms = 48'hFFFF_FFFF_FFFF;
		send_request(make_req(OP_SWEEP, 0, 0, 0, 0, 1));
		send_request(make_req(OP_FIND, 0, 0, 0, 0, 1));
		send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 1));
		clock_ms = 0;
		drain();
	endtask

	task automatic test_random(input int count, input logic [31:0] ret,
			input logic [3:0] unav, input logic [3:0] high);
		write_reg(REG_RET, ret);
		write_reg(REG_UNAV, unav);
		write_reg(REG_HIGH, high);
		for (int n = 0; n < count; n++)
			send_request(($urandom_range(0, 9) == 0) ? noise_request() : life_request());
		drain();
	endtask

	task automatic test_backpressure;
		hold_off = 400;
		for (int n = 0; n < 20; n++) send_request(life_request());
		drain();
	endtask

	initial begin
		foreach (table_q[k]) table_q[k] = '0;
		next_id = 1;
		r_boot = 0;
		r_ret = 5000;
		r_unav = 1;
		r_high = 15;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_random(500, 5000, 1, 15);
		test_random(400, 0, 3, 1);
		test_random(400, 32'hFFFF_FFFF, 15, 8);
		test_backpressure();
		write_reg(REG_BOOT, 0);
		test_random(100, 2000, 1, 15);
		write_reg(REG_BOOT, 32'h1);
		test_random(450, 3000, 2, 15);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
